>>> rtl/b64d_pkg.sv
// b64d_pkg: shared constants, result types and the alphabet lookup of the base64 decoder
// depends on nothing; used by the interfaces and by every rtl module
package b64d_pkg;

    // longest accepted string, in characters
    localparam int MAX_CHARS = 1024;
    // character counter saturates at MAX_CHARS + 1
    localparam int CNT_W = $clog2(MAX_CHARS + 2);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHARS);

    localparam int STATUS_W = 3;
    localparam logic [STATUS_W-1:0] ST_OK   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LONG = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LEN  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CHAR = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PAD  = 3'd4;

    localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

    // results one character can cause: three bytes and a status
    localparam int SLOTS   = 4;
    localparam int SLOT_CW = $clog2(SLOTS + 1);

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0]          out_byte;
        logic                is_status;
        logic [STATUS_W-1:0] status;
        logic                last_result;
    } result_t;

    // results produced by one character, packed from slot 0 upward
    typedef struct packed {
        logic [SLOT_CW-1:0]       count;
        result_t [SLOTS-1:0]      slot;
    } burst_t;

    // {valid, sextet} for one character of the standard alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] v;
        logic       ok;
        v  = 8'd0;
        ok = 1'b1;
        if (c inside {[8'h41:8'h5A]}) begin
            v = c - 8'h41;
        end else if (c inside {[8'h61:8'h7A]}) begin
            v = c - 8'h61 + 8'd26;
        end else if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30 + 8'd52;
        end else if (c == 8'h2B) begin
            v = 8'd62;
        end else if (c == 8'h2F) begin
            v = 8'd63;
        end else begin
            ok = 1'b0;
        end
        return {ok, v[5:0]};
    endfunction

endpackage

>>> rtl/b64d_ifs.sv
// b64d_ifs: valid/ready channel interfaces for characters and decoded results
// depends on b64d_pkg
interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       last;

    modport source (output valid, output in_char, output last, input ready);
    modport sink (input valid, input in_char, input last, output ready);
endinterface

interface b64d_result_if;
    logic                         valid;
    logic                         ready;
    logic [7:0]                   out_byte;
    logic                         is_status;
    logic [b64d_pkg::STATUS_W-1:0] status;
    logic                         last_result;

    modport source (output valid, output out_byte, output is_status, output status,
                    output last_result, input ready);
    modport sink (input valid, input out_byte, input is_status, input status,
                  input last_result, output ready);
endinterface

>>> rtl/b64d_decode.sv
// b64d_decode: group state and per-character decode into up to four results
// depends on b64d_pkg
module b64d_decode (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  logic [7:0]             in_char,
    input  logic                   last,
    output b64d_pkg::burst_t       burst
);

    logic [1:0]                    pos_reg, pos_next;
    logic [17:0]                   acc_reg, acc_next;
    logic                          twp_reg, twp_next;
    logic [b64d_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [b64d_pkg::STATUS_W-1:0] err_reg, err_next;

    logic [6:0]                    lookup;
    logic                          pad;
    logic [5:0]                    sext;
    logic [23:0]                   value;
    logic [b64d_pkg::STATUS_W-1:0] err_c;
    logic [b64d_pkg::STATUS_W-1:0] st;
    logic [b64d_pkg::SLOT_CW-1:0]  n;
    b64d_pkg::result_t             res;

    assign lookup = b64d_pkg::sextet_of(in_char);
    assign pad    = (in_char == b64d_pkg::PAD_CHAR) && pos_reg[1];
    assign sext   = (pad || !lookup[6]) ? 6'd0 : lookup[5:0];
    assign value  = {acc_reg, sext};

    always_comb
    begin
        pos_next = pos_reg;
        acc_next = acc_reg;
        twp_next = twp_reg;
        err_c    = err_reg;
        st       = b64d_pkg::ST_OK;
        n        = '0;
        res      = '0;
        burst    = '0;

        cnt_next = (cnt_reg <= b64d_pkg::MAX_CNT) ? cnt_reg + 1'b1 : cnt_reg;
        if (!pad && !lookup[6] && err_c == b64d_pkg::ST_OK) begin
            err_c = b64d_pkg::ST_CHAR;
        end

        if (pos_reg != 2'd3) begin
            acc_next = {acc_reg[11:0], sext};
            if (pos_reg == 2'd2) begin
                twp_next = pad;
            end
            pos_next = pos_reg + 2'd1;
        end else begin
            // group complete: check padding, then emit bytes
            if (err_c == b64d_pkg::ST_OK &&
                ((twp_reg && !pad) || ((twp_reg || pad) && !last))) begin
                err_c = b64d_pkg::ST_PAD;
            end
            if (err_c == b64d_pkg::ST_OK && cnt_next <= b64d_pkg::MAX_CNT) begin
                res = '0;
                res.out_byte = value[23:16];
                burst.slot[n[1:0]] = res;
                n = n + 1'b1;
                if (!twp_reg) begin
                    res.out_byte = value[15:8];
                    burst.slot[n[1:0]] = res;
                    n = n + 1'b1;
                end
                if (!pad) begin
                    res.out_byte = value[7:0];
                    burst.slot[n[1:0]] = res;
                    n = n + 1'b1;
                end
            end
            pos_next = 2'd0;
            acc_next = '0;
            twp_next = 1'b0;
        end
        err_next = err_c;

        if (last) begin
            if (cnt_next > b64d_pkg::MAX_CNT) begin
                st = b64d_pkg::ST_LONG;
            end else if (pos_next != 2'd0) begin
                st = b64d_pkg::ST_LEN;
            end else begin
                st = err_c;
            end
            res             = '0;
            res.is_status   = 1'b1;
            res.status      = st;
            res.last_result = 1'b1;
            burst.slot[n[1:0]] = res;
            n = n + 1'b1;
            pos_next = 2'd0;
            acc_next = '0;
            twp_next = 1'b0;
            cnt_next = '0;
            err_next = b64d_pkg::ST_OK;
        end
        burst.count = fire ? n : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= '0;
            acc_reg <= '0;
            twp_reg <= 1'b0;
            cnt_reg <= '0;
            err_reg <= b64d_pkg::ST_OK;
        end else if (fire) begin
            pos_reg <= pos_next;
            acc_reg <= acc_next;
            twp_reg <= twp_next;
            cnt_reg <= cnt_next;
            err_reg <= err_next;
        end
    end

endmodule

>>> rtl/b64d_queue.sv
// b64d_queue: result queue taking up to four results a cycle and giving one
// depends on b64d_pkg
module b64d_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  b64d_pkg::burst_t              burst,
    input  logic                          pop,
    output b64d_pkg::result_t             head,
    output logic                          not_empty,
    output logic                          has_room
);

    b64d_pkg::result_t                 mem [b64d_pkg::FIFO_DEPTH];
    logic [b64d_pkg::FIFO_AW-1:0]      wr_ptr_reg;
    logic [b64d_pkg::FIFO_AW-1:0]      rd_ptr_reg;
    logic [b64d_pkg::FIFO_CW-1:0]      count_reg;
    logic                              do_pop;

    assign not_empty = (count_reg != '0);
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];
    // room for a full burst of results
    assign has_room  = (count_reg <= b64d_pkg::FIFO_CW'(b64d_pkg::FIFO_DEPTH - b64d_pkg::SLOTS));

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < b64d_pkg::SLOTS; i++) begin
            if (b64d_pkg::SLOT_CW'(i) < burst.count) begin
                mem[wr_ptr_reg + b64d_pkg::FIFO_AW'(i)] <= burst.slot[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + b64d_pkg::FIFO_AW'(burst.count);
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + b64d_pkg::FIFO_CW'(burst.count)
                         - b64d_pkg::FIFO_CW'(do_pop);
        end
    end

endmodule

>>> rtl/base64_strict_decoder_core.sv
// base64_strict_decoder_core: streaming strict base64 decoder, top level
// depends on b64d_pkg, b64d_ifs, b64d_decode, b64d_queue
//
//   channel   dir   beat payload                             handshake
//   chars     in    in_char[7:0], last                       valid/ready
//   results   out   out_byte[7:0], is_status, status[2:0],   valid/ready
//                   last_result
//
// one character per cycle is accepted while the queue has room; a character
// waits in the input register, is decoded there and its zero to four results
// enter an 8-entry result queue, from which one beat per cycle leaves while
// results is ready; the character register advances only while the queue has
// room for four results, so a stalled results channel backs up into chars
// rst_n clears the group state, the staged valid bit and the queue pointers
module base64_strict_decoder_core (
    input  logic                 clk,
    input  logic                 rst_n,
    b64d_char_if.sink            chars,
    b64d_result_if.source        results
);

    // input register
    logic       stage_valid_reg;
    logic [7:0] stage_char_reg;
    logic       stage_last_reg;

    logic              stage_go;
    logic              has_room;
    logic              not_empty;
    b64d_pkg::burst_t  burst;
    b64d_pkg::result_t head;

    // the staged character is decoded once the queue can take a full burst
    assign stage_go    = stage_valid_reg && has_room;
    assign chars.ready = !stage_valid_reg || stage_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
        end else if (chars.ready) begin
            stage_valid_reg <= chars.valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid) begin
            stage_char_reg <= chars.in_char;
            stage_last_reg <= chars.last;
        end
    end

    // group state and decode of the staged character
    b64d_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (stage_go),
        .in_char (stage_char_reg),
        .last    (stage_last_reg),
        .burst   (burst)
    );

    // result queue between decode and the results channel
    b64d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .burst     (burst),
        .pop       (results.ready),
        .head      (head),
        .not_empty (not_empty),
        .has_room  (has_room)
    );

    assign results.valid       = not_empty;
    assign results.out_byte    = head.out_byte;
    assign results.is_status   = head.is_status;
    assign results.status      = head.status;
    assign results.last_result = head.last_result;

endmodule

>>> tb/base64_strict_decoder_core_tb.sv
// base64_strict_decoder_core_tb: self-checking testbench for the strict base64 decoder core
// depends on b64d_pkg, b64d_ifs and base64_strict_decoder_core from the rtl folder
// drives characters over valid/ready, predicts every result beat and checks it in order
`timescale 1ns / 1ps

module base64_strict_decoder_core_tb;

    import b64d_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_CHARS = 345;
    localparam int SIDE_SEND = 0;
    localparam int SIDE_RECV = 1;

    logic clk = 1'b0;
    logic rst_n;

    b64d_char_if   chars_if ();
    b64d_result_if results_if ();

    base64_strict_decoder_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (results_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // directed strings, each closed by last; the status of each is typed in
    string      dir_text[7]   = '{"AAAA", "////", "QQ==", "QUE=", "Q", "=\377=A", "AA=A"};
    logic [2:0] dir_status[7] = '{ST_OK, ST_OK, ST_OK, ST_OK, ST_LEN, ST_CHAR, ST_PAD};

    string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // decoder state as seen by the predictor
    logic [1:0]       grp_pos;
    logic [17:0]      acc;
    logic             third_pad;
    logic [CNT_W-1:0] char_cnt;
    logic [2:0]       first_err;

    result_t    pending_results[$];
    logic [7:0] str_buf[$];

    int unsigned cycle_cnt = 0;
    int          mismatch_cnt = 0;
    int          n_strings = 0;
    int          n_chars = 0;
    int          n_bytes_out = 0;
    int          status_tally[5] = '{0, 0, 0, 0, 0};
    bit          calm[2] = '{0, 0};

    always @(posedge clk)
        cycle_cnt <= cycle_cnt + 1;

    function automatic int sextet_value(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return c - "A";
        if (c >= "a" && c <= "z") return c - "a" + 26;
        if (c >= "0" && c <= "9") return c - "0" + 52;
        if (c == "+") return 62;
        if (c == "/") return 63;
        return -1;
    endfunction

    function automatic result_t byte_beat(input logic [7:0] b);
        result_t r;
        r = '{out_byte: b, is_status: 1'b0, status: ST_OK, last_result: 1'b0};
        return r;
    endfunction

    // append one expected beat behind the ones already waiting
    function automatic void queue_expected(input result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void append_char(input logic [7:0] c);
        str_buf.insert(str_buf.size(), c);
    endfunction

    function automatic void clear_group_state();
        grp_pos   = '0;
        acc       = '0;
        third_pad = 1'b0;
        char_cnt  = '0;
        first_err = ST_OK;
    endfunction

    // one accepted character: update the state and queue what it produces
    function automatic void decode_char(input logic [7:0] c, input logic lst,
                                        input bit use_typed, input logic [2:0] typed_st);
        logic [1:0]  pos;
        logic        pad;
        int          sv;
        logic [5:0]  sext;
        logic [23:0] word;
        logic [2:0]  st;
        result_t     r;
        pos = grp_pos;
        pad = (c == PAD_CHAR) && (pos >= 2);
        sv  = sextet_value(c);
        if (char_cnt <= MAX_CNT)
            char_cnt = char_cnt + 1'b1;
        if (!pad && sv < 0 && first_err == ST_OK)
            first_err = ST_CHAR;
        sext = (pad || sv < 0) ? 6'd0 : sv[5:0];
        if (pos < 3)
        begin
            acc = {acc[11:0], sext};
            if (pos == 2)
                third_pad = pad;
            grp_pos = pos + 1'b1;
        end
        else
        begin
            word = {acc, sext};
            // padding is legal only in the final group, and a padded third needs a padded fourth
            if (first_err == ST_OK && ((third_pad && !pad) || ((third_pad || pad) && !lst)))
                first_err = ST_PAD;
            if (first_err == ST_OK && char_cnt <= MAX_CNT)
            begin
                queue_expected(byte_beat(word[23:16]));
                if (!third_pad)
                    queue_expected(byte_beat(word[15:8]));
                if (!pad)
                    queue_expected(byte_beat(word[7:0]));
            end
            grp_pos   = '0;
            acc       = '0;
            third_pad = 1'b0;
        end
        if (lst)
        begin
            if (char_cnt > MAX_CNT)
                st = ST_LONG;
            else if (grp_pos != 0)
                st = ST_LEN;
            else
                st = first_err;
            r = '{out_byte: 8'd0, is_status: 1'b1, status: use_typed ? typed_st : st,
                  last_result: 1'b1};
            queue_expected(r);
            clear_group_state();
        end
    endfunction

    // idle cycles before the next beat; calm stretches give back-to-back traffic
    function automatic int next_wait(input int side);
        if ($urandom_range(0, 24) == 0)
            calm[side] = !calm[side];
        return calm[side] ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic logic [7:0] pick_alpha();
        return alphabet[$urandom_range(0, 63)];
    endfunction

    // entered at a falling edge, returns at the falling edge after the beat
    task automatic send_char(input logic [7:0] c, input logic lst,
                             input bit use_typed, input logic [2:0] typed_st);
        int gap;
        gap = next_wait(SIDE_SEND);
        if (gap > 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        chars_if.valid   <= 1'b1;
        chars_if.in_char <= c;
        chars_if.last    <= lst;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        decode_char(c, lst, use_typed, typed_st);
        n_chars++;
        @(negedge clk);
    endtask

    task automatic send_string(input bit use_typed, input logic [2:0] typed_st);
        int k;
        for (k = 0; k < str_buf.size(); k++)
            send_char(str_buf[k], k == str_buf.size() - 1, use_typed, typed_st);
        n_strings++;
    endtask

    task automatic fill_groups(input int groups);
        int k;
        str_buf.delete();
        for (k = 0; k < groups * 4; k++)
            append_char(pick_alpha());
    endtask

    // mostly well-formed strings with random content, the rest broken on purpose
    task automatic make_random_string();
        int kind;
        int groups;
        int padn;
        int k;
        int n;
        kind   = $urandom_range(0, 9);
        groups = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        padn   = $urandom_range(0, 2);
        fill_groups(groups);
        if (padn > 0)
            str_buf[groups * 4 - 1] = PAD_CHAR;
        if (padn == 2)
            str_buf[groups * 4 - 2] = PAD_CHAR;
        case (kind)
            7:
            begin
                // one character anywhere replaced by any byte, often '='
                k = $urandom_range(0, str_buf.size() - 1);
                str_buf[k] = ($urandom_range(0, 3) == 0) ? PAD_CHAR : 8'($urandom_range(0, 255));
            end
            8:
            begin
                // length off by one to three
                n = $urandom_range(1, 3);
                if ($urandom_range(0, 1) == 1 && str_buf.size() > n)
                    repeat (n) void'(str_buf.pop_back());
                else
                    repeat (n) append_char(($urandom_range(0, 3) == 0) ?
                                           8'($urandom_range(0, 255)) : pick_alpha());
            end
            9:
            begin
                if (groups > 1)
                begin
                    // padded group before the final one
                    k = 4 * $urandom_range(0, groups - 2);
                    str_buf[k + 3] = PAD_CHAR;
                    if ($urandom_range(0, 1) == 1)
                        str_buf[k + 2] = PAD_CHAR;
                end
                else
                begin
                    // padded third followed by a data character
                    str_buf[2] = PAD_CHAR;
                    str_buf[3] = pick_alpha();
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatch_cnt++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // result side: random ready, every accepted beat checked against the oldest expectation
    initial
    begin
        int      gap;
        result_t want;
        results_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = next_wait(SIDE_RECV);
            if (gap > 0)
            begin
                results_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            results_if.ready <= 1'b1;
            @(posedge clk);
            while (!results_if.valid)
                @(posedge clk);
            if (results_if.is_status && results_if.status <= ST_PAD)
                status_tally[results_if.status]++;
            else if (!results_if.is_status)
                n_bytes_out++;
            if (pending_results.size() == 0)
            begin
                mismatch_cnt++;
                $display("%0t: unexpected beat, byte %02h status %0d/%0d last %0d", $time,
                         results_if.out_byte, results_if.is_status, results_if.status,
                         results_if.last_result);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("out_byte", want.out_byte, results_if.out_byte);
                check_field("is_status", want.is_status, results_if.is_status);
                check_field("status", want.status, results_if.status);
                check_field("last_result", want.last_result, results_if.last_result);
            end
            @(negedge clk);
        end
    end

    initial
    begin
        wait (cycle_cnt == CYCLE_LIMIT);
        $display("tb: gave up after %0d cycles with %0d beats outstanding", CYCLE_LIMIT,
                 pending_results.size());
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int i;
        int k;
        int rand_chars;
        chars_if.valid   = 1'b0;
        chars_if.in_char = 8'd0;
        chars_if.last    = 1'b0;
        rst_n            = 1'b0;
        clear_group_state();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: byte extremes, one- and two-byte padding, short string,
        // bad character beating bad padding, data after a padded third
        for (i = 0; i < 7; i++)
        begin
            str_buf.delete();
            for (k = 0; k < dir_text[i].len(); k++)
                append_char(dir_text[i][k]);
            send_string(1'b1, dir_status[i]);
        end

        // hold off until the result side has drained everything
        chars_if.valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);

        rand_chars = 0;
        while (rand_chars < RANDOM_CHARS)
        begin
            make_random_string();
            rand_chars += str_buf.size();
            send_string(1'b0, ST_OK);
        end

        chars_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("tb: %0d strings, %0d characters in, %0d bytes out", n_strings, n_chars,
                 n_bytes_out);
        $display("tb: status ok %0d, too long %0d, bad length %0d, bad char %0d, bad pad %0d",
                 status_tally[ST_OK], status_tally[ST_LONG], status_tally[ST_LEN],
                 status_tally[ST_CHAR], status_tally[ST_PAD]);
        if (mismatch_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
